// ===== rtl/ssh_plaintext_packet_deframer_core_macros.svh =====
// Assertion macros shared by the deframer modules.
`ifndef SSH_PLAINTEXT_PACKET_DEFRAMER_CORE_MACROS_SVH
`define SSH_PLAINTEXT_PACKET_DEFRAMER_CORE_MACROS_SVH
`ifndef SYNTH
`define SSH_DFR_ASSERT(label, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSH_DFR_NEVER(label, cond, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SSH_DFR_ASSERT(label, prop, msg)
`define SSH_DFR_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/ssh_dfr_pkg.sv =====
// Types and constants of the plaintext packet deframer.
package ssh_dfr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W = 16;
    localparam int SEQ_W = 32;
    localparam int HDR_W = 32;
    localparam int HDR_CNT_W = 2;
    localparam int HEADER_BYTES = 4;
    localparam int MIN_PACKET_LENGTH = 2;

    localparam logic [LEN_W-1:0] MAX_PACKET_RESET = 16'd32764;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd32768;

    localparam int CFG_IDX_W = 1;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_PACKET = 1'b0,
        CFG_MAX_PAYLOAD = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PADLEN = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD_PACKET = 2'd2,
        KIND_BAD_PAYLOAD = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0] plen;
        logic [SEQ_W-1:0] seq;
        logic last;
    } res_t;

    // Up to two results come out of one byte, in order first then second.
    typedef struct packed {
        logic [1:0] count;
        res_t first;
        res_t second;
    } push_t;

endpackage

// ===== rtl/ssh_plaintext_packet_deframer_core.sv =====
// Top level of the plaintext packet deframer: input register, parser, result queue.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_byte
//   out      output     out_valid / out_stall  kind, out_byte, payload_length,
//                                              sequence_res, last
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low. A byte waits in the input register,
// its results go into the result queue, and a second result, if any, follows the first.
// The parser is combinational on the input register's byte, and the four-entry
// result queue absorbs the two results of a packet ending with no padding.
// Reset is asynchronous and takes effect at once; there is no clearing pass.
// A stall on the output piles up results; with three or more queued, a byte in the input
// register is held there and in_stall rises.
module ssh_plaintext_packet_deframer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ssh_dfr_pkg::BYTE_W-1:0]     in_byte,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ssh_dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssh_dfr_pkg::LEN_W-1:0]      cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         kind,
    output logic [ssh_dfr_pkg::BYTE_W-1:0]     out_byte,
    output logic [ssh_dfr_pkg::LEN_W-1:0]      payload_length,
    output logic [ssh_dfr_pkg::SEQ_W-1:0]      sequence_res,
    output logic                               last
);

    logic in_full_reg, in_full_next;
    logic [ssh_dfr_pkg::BYTE_W-1:0] in_byte_reg;
    logic advance;
    logic accept;
    logic room;
    ssh_dfr_pkg::push_t push;
    ssh_dfr_pkg::res_t head;

    assign cfg_ready = 1'b1;
    assign advance = in_full_reg && room;
    assign in_stall = in_full_reg && !advance;
    assign accept = in_valid && !in_stall;
    assign in_full_next = accept || (in_full_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_byte;
        end
    end

    ssh_dfr_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .in_byte   (in_byte_reg),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    ssh_dfr_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign kind = head.kind;
    assign out_byte = head.data;
    assign payload_length = head.plen;
    assign sequence_res = head.seq;
    assign last = head.last;

endmodule

// ===== rtl/ssh_dfr_parse.sv =====
// Packet parser: header, padding length and body tracking, result generation.
`include "ssh_plaintext_packet_deframer_core_macros.svh"

module ssh_dfr_parse (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic [ssh_dfr_pkg::BYTE_W-1:0]     in_byte,
    input  logic                               cfg_valid,
    input  logic [ssh_dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssh_dfr_pkg::LEN_W-1:0]      cfg_data,
    output ssh_dfr_pkg::push_t                 push
);

    ssh_dfr_pkg::phase_t phase_reg, phase_next;
    logic [ssh_dfr_pkg::HDR_W-1:0] length_shift_reg, length_shift_next;
    logic [ssh_dfr_pkg::HDR_CNT_W-1:0] header_count_reg, header_count_next;
    logic [ssh_dfr_pkg::LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [ssh_dfr_pkg::LEN_W-1:0] payload_left_reg, payload_left_next;
    logic [ssh_dfr_pkg::LEN_W-1:0] payload_total_reg, payload_total_next;
    logic [ssh_dfr_pkg::SEQ_W-1:0] receive_sequence_reg, receive_sequence_next;
    logic [ssh_dfr_pkg::LEN_W-1:0] max_packet_reg;
    logic [ssh_dfr_pkg::LEN_W-1:0] max_payload_reg;

    logic [ssh_dfr_pkg::HDR_W-1:0] shift_cat;
    logic hdr_full;
    logic hdr_bad;
    logic [ssh_dfr_pkg::LEN_W-1:0] byte_wide;
    logic pad_short;
    logic [ssh_dfr_pkg::LEN_W-1:0] pad_rem;
    logic pad_bad;
    logic emit_pay;
    logic [ssh_dfr_pkg::LEN_W-1:0] bl_dec;
    logic body_done;

    function automatic ssh_dfr_pkg::res_t make_res(
        input ssh_dfr_pkg::kind_t k,
        input logic [ssh_dfr_pkg::BYTE_W-1:0] d,
        input logic [ssh_dfr_pkg::LEN_W-1:0] pl,
        input logic [ssh_dfr_pkg::SEQ_W-1:0] sq,
        input logic lst
    );
        ssh_dfr_pkg::res_t r;
        r.kind = k;
        r.data = d;
        r.plen = pl;
        r.seq = sq;
        r.last = lst;
        return r;
    endfunction

    // The length field is big-endian, so each header byte enters at the bottom.
    assign shift_cat = {length_shift_reg[ssh_dfr_pkg::HDR_W-ssh_dfr_pkg::BYTE_W-1:0], in_byte};
    assign hdr_full = header_count_reg ==
                      ssh_dfr_pkg::HDR_CNT_W'(ssh_dfr_pkg::HEADER_BYTES - 1);
    assign hdr_bad = (shift_cat < ssh_dfr_pkg::HDR_W'(ssh_dfr_pkg::MIN_PACKET_LENGTH)) ||
                     (shift_cat > {{(ssh_dfr_pkg::HDR_W-ssh_dfr_pkg::LEN_W){1'b0}},
                                   max_packet_reg});

    // In the padding length phase bytes_left still holds the packet length.
    assign byte_wide = {{(ssh_dfr_pkg::LEN_W-ssh_dfr_pkg::BYTE_W){1'b0}}, in_byte};
    assign pad_short = byte_wide >= bytes_left_reg;
    assign pad_rem = bytes_left_reg - byte_wide - ssh_dfr_pkg::LEN_W'(1);
    assign pad_bad = pad_short || (pad_rem > max_payload_reg);

    assign emit_pay = payload_left_reg != '0;
    assign bl_dec = (bytes_left_reg != '0) ? bytes_left_reg - ssh_dfr_pkg::LEN_W'(1) : '0;
    assign body_done = bl_dec == '0;

    always_comb
    begin
        unique case (phase_reg)
            ssh_dfr_pkg::PH_PADLEN:
            begin
                phase_next = pad_bad ? ssh_dfr_pkg::PH_HEADER : ssh_dfr_pkg::PH_BODY;
            end
            ssh_dfr_pkg::PH_BODY:
            begin
                phase_next = body_done ? ssh_dfr_pkg::PH_HEADER : ssh_dfr_pkg::PH_BODY;
            end
            default:
            begin
                phase_next = (hdr_full && !hdr_bad) ? ssh_dfr_pkg::PH_PADLEN
                                                    : ssh_dfr_pkg::PH_HEADER;
            end
        endcase
    end

    always_comb
    begin
        length_shift_next = length_shift_reg;
        header_count_next = header_count_reg;
        bytes_left_next = bytes_left_reg;
        payload_left_next = payload_left_reg;
        payload_total_next = payload_total_reg;
        receive_sequence_next = receive_sequence_reg;
        push = '0;
        unique case (phase_reg)
            ssh_dfr_pkg::PH_PADLEN:
            begin
                if (pad_bad)
                begin
                    push.count = 2'd1;
                    push.first = make_res(ssh_dfr_pkg::KIND_BAD_PAYLOAD, '0, '0, '0, 1'b1);
                end
                else
                begin
                    payload_total_next = pad_rem;
                    payload_left_next = pad_rem;
                    bytes_left_next = bytes_left_reg - ssh_dfr_pkg::LEN_W'(1);
                end
            end
            ssh_dfr_pkg::PH_BODY:
            begin
                bytes_left_next = bl_dec;
                if (emit_pay)
                begin
                    payload_left_next = payload_left_reg - ssh_dfr_pkg::LEN_W'(1);
                end
                if (body_done)
                begin
                    receive_sequence_next = receive_sequence_reg + ssh_dfr_pkg::SEQ_W'(1);
                end
                if (emit_pay && body_done)
                begin
                    push.count = 2'd2;
                    push.first = make_res(ssh_dfr_pkg::KIND_PAYLOAD, in_byte, '0, '0, 1'b0);
                    push.second = make_res(ssh_dfr_pkg::KIND_DONE, '0, payload_total_reg,
                                           receive_sequence_reg, 1'b1);
                end
                else if (emit_pay)
                begin
                    push.count = 2'd1;
                    push.first = make_res(ssh_dfr_pkg::KIND_PAYLOAD, in_byte, '0, '0, 1'b1);
                end
                else if (body_done)
                begin
                    push.count = 2'd1;
                    push.first = make_res(ssh_dfr_pkg::KIND_DONE, '0, payload_total_reg,
                                          receive_sequence_reg, 1'b1);
                end
            end
            default:
            begin
                if (hdr_full)
                begin
                    length_shift_next = '0;
                    header_count_next = '0;
                    if (hdr_bad)
                    begin
                        push.count = 2'd1;
                        push.first = make_res(ssh_dfr_pkg::KIND_BAD_PACKET,
                                              '0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        bytes_left_next = shift_cat[ssh_dfr_pkg::LEN_W-1:0];
                    end
                end
                else
                begin
                    length_shift_next = shift_cat;
                    header_count_next = header_count_reg + ssh_dfr_pkg::HDR_CNT_W'(1);
                end
            end
        endcase
        if (!step)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ssh_dfr_pkg::PH_HEADER;
            length_shift_reg <= '0;
            header_count_reg <= '0;
            bytes_left_reg <= '0;
            payload_left_reg <= '0;
            payload_total_reg <= '0;
            receive_sequence_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            length_shift_reg <= length_shift_next;
            header_count_reg <= header_count_next;
            bytes_left_reg <= bytes_left_next;
            payload_left_reg <= payload_left_next;
            payload_total_reg <= payload_total_next;
            receive_sequence_reg <= receive_sequence_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packet_reg <= ssh_dfr_pkg::MAX_PACKET_RESET;
            max_payload_reg <= ssh_dfr_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (ssh_dfr_pkg::cfg_index_t'(cfg_index))
                ssh_dfr_pkg::CFG_MAX_PACKET:  max_packet_reg <= cfg_data;
                ssh_dfr_pkg::CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default:                      max_packet_reg <= max_packet_reg;
            endcase
        end
    end

    // The packet length is at least two, so a body always has a byte left to count.
    `SSH_DFR_ASSERT(a_body_left, phase_reg == ssh_dfr_pkg::PH_BODY |-> bytes_left_reg != '0, "body phase with no bytes left")
    `SSH_DFR_ASSERT(a_payload_fits, phase_reg == ssh_dfr_pkg::PH_BODY |-> payload_left_reg <= bytes_left_reg, "payload count exceeds body count")
    `SSH_DFR_ASSERT(a_seq_on_done, receive_sequence_reg != $past(receive_sequence_reg) |-> $past(step && phase_reg == ssh_dfr_pkg::PH_BODY && body_done), "sequence moved without a finished packet")

endmodule

// ===== rtl/ssh_dfr_resq.sv =====
// Result queue: takes up to two results a cycle and hands them out one at a time.
`include "ssh_plaintext_packet_deframer_core_macros.svh"

module ssh_dfr_resq (
    input  logic               clk,
    input  logic               rst_n,
    input  ssh_dfr_pkg::push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output ssh_dfr_pkg::res_t  head
);

    ssh_dfr_pkg::res_t mem_reg [ssh_dfr_pkg::RQ_DEPTH];
    logic [ssh_dfr_pkg::RQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ssh_dfr_pkg::RQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ssh_dfr_pkg::RQ_CNT_W-1:0] count_reg, count_next;
    logic [ssh_dfr_pkg::RQ_PTR_W-1:0] wr_ptr_second;
    logic pop;

    assign out_valid = count_reg != '0;
    assign head = mem_reg[rd_ptr_reg];
    assign pop = out_valid && !out_stall;
    // Room for a full two-result request, judged on the registered count alone.
    assign room = count_reg <= ssh_dfr_pkg::RQ_CNT_W'(ssh_dfr_pkg::RQ_DEPTH - 2);
    assign wr_ptr_second = wr_ptr_reg + ssh_dfr_pkg::RQ_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ssh_dfr_pkg::RQ_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + ssh_dfr_pkg::RQ_PTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + ssh_dfr_pkg::RQ_CNT_W'(push.count)
                     - ssh_dfr_pkg::RQ_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    `SSH_DFR_NEVER(a_rq_bound, count_reg > ssh_dfr_pkg::RQ_CNT_W'(ssh_dfr_pkg::RQ_DEPTH), "result queue over capacity")
    `SSH_DFR_NEVER(a_rq_room, push.count != 2'd0 && !room, "request pushed without room")
    `SSH_DFR_ASSERT(a_done_last, out_valid && head.kind == ssh_dfr_pkg::KIND_DONE |-> head.last, "packet done marker not flagged last")

endmodule
